// File: rtl/core/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared types, character codes and status codes for the GUID text parser.
// ----------------------------------------------------------------------------
package gtp_pkg;

    localparam int CHAR_W = 16;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [1:0]        status_t;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NO_HEX  = 2'd1;
    localparam status_t ST_BAD_SEP = 2'd2;

    localparam logic KIND_RESULT  = 1'b0;
    localparam logic KIND_COMMENT = 1'b1;

    localparam char_t CH_NUL   = 16'h0000;
    localparam char_t CH_TAB   = 16'h0009;
    localparam char_t CH_SPACE = 16'h0020;
    localparam char_t CH_DASH  = 16'h002D;
    localparam char_t CH_SLASH = 16'h002F;

    localparam logic [3:0] G1_DIGITS  = 4'd8;
    localparam logic [3:0] GRP_DIGITS = 4'd4;

    function automatic logic is_hex(input char_t c);
        is_hex = (c >= 16'h0030 && c <= 16'h0039) ||
                 (c >= 16'h0061 && c <= 16'h0066) ||
                 (c >= 16'h0041 && c <= 16'h0046);
    endfunction

    function automatic logic [3:0] hex_val(input char_t c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            v = c[3:0];
        end else if ((c >= 16'h0061 && c <= 16'h0066) ||
                     (c >= 16'h0041 && c <= 16'h0046)) begin
            // 'a'/'A' end in 1 .. 'f'/'F' end in 6
            v = 4'd9 + c[3:0];
        end
        hex_val = v;
    endfunction

endpackage

// File: rtl/core/guid_text_parser.sv
// A word is registered and is on m_* in the cycle after the character that causes it.
// Throughput: one character per cycle; the parse state and the output register
// both update in the same cycle, so s_ready drops only while m_* holds a word
// that is not taken (s_ready = !m_valid || m_ready).
// Reset (aresetn low, synchronous): back to the seek phase, accumulators cleared,
// output word dropped.
// ----------------------------------------------------------------------------
// guid_text_parser
// Streaming parser of GUID text with an optional trailing comment; one
// 16-bit character per word, NUL ends the string and emits the result.
// ----------------------------------------------------------------------------
module guid_text_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gtp_pkg::char_t       s_ch,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_kind,
    output gtp_pkg::char_t       m_comment_char,
    output gtp_pkg::status_t     m_status,
    output logic [31:0]          m_part_one,
    output logic [15:0]          m_part_two,
    output logic [15:0]          m_part_three,
    output logic [63:0]          m_tail_bytes,
    output logic                 m_comment_found
);
    import gtp_pkg::*;

    typedef enum logic [3:0] {
        PH_SEEK    = 4'd0,
        PH_G1      = 4'd1,
        PH_G2      = 4'd2,
        PH_G3      = 4'd3,
        PH_G4      = 4'd4,
        PH_G5      = 4'd5,
        PH_G6      = 4'd6,
        PH_G7      = 4'd7,
        PH_SLASH   = 4'd8,
        PH_SKIP1   = 4'd9,
        PH_WHITE   = 4'd10,
        PH_COMMENT = 4'd11,
        PH_DRAIN   = 4'd12
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [31:0] acc_one_reg, acc_one_next;
    logic [15:0] acc_two_reg, acc_two_next;
    logic [15:0] acc_three_reg, acc_three_next;
    logic [63:0] acc_tail_reg, acc_tail_next;
    status_t     err_reg, err_next;
    logic        slash_reg, slash_next;

    logic        m_valid_reg;
    logic        m_kind_reg, m_kind_next;
    char_t       m_char_reg, m_char_next;
    status_t     m_status_reg, m_status_next;
    logic [31:0] m_one_reg, m_one_next;
    logic [15:0] m_two_reg, m_two_next;
    logic [15:0] m_three_reg, m_three_next;
    logic [63:0] m_tail_reg, m_tail_next;
    logic        m_found_reg, m_found_next;

    logic        accept;
    logic        emit;
    logic        hx;
    logic [3:0]  dv;
    logic        post;       // character goes on to the slash/comment stage
    phase_t      post_phase;
    logic [1:0]  slot;       // 16-bit slot of acc_tail, 0 = least significant
    logic        tail_wr;
    logic [3:0]  count_inc;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign hx        = is_hex(s_ch);
    assign dv        = hex_val(s_ch);
    assign count_inc = count_reg + 4'd1;

    always_comb begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        acc_one_next   = acc_one_reg;
        acc_two_next   = acc_two_reg;
        acc_three_next = acc_three_reg;
        acc_tail_next  = acc_tail_reg;
        err_next       = err_reg;
        slash_next     = slash_reg;
        emit           = 1'b0;
        m_kind_next    = KIND_RESULT;
        m_char_next    = CH_NUL;
        m_status_next  = ST_OK;
        m_one_next     = '0;
        m_two_next     = '0;
        m_three_next   = '0;
        m_tail_next    = '0;
        m_found_next   = 1'b0;
        post           = 1'b0;
        post_phase     = phase_reg;
        slot           = 2'd3;
        tail_wr        = 1'b0;

        case (phase_reg)
            PH_SEEK: begin
                if (hx) begin
                    acc_one_next = {28'd0, dv};
                    count_next   = 4'd1;
                    phase_next   = PH_G1;
                end else if (s_ch == CH_NUL) begin
                    emit     = 1'b1;
                    err_next = ST_NO_HEX;
                end
            end
            PH_G1, PH_G2, PH_G3, PH_G4: begin
                if (hx && count_reg < ((phase_reg == PH_G1) ? G1_DIGITS : GRP_DIGITS)) begin
                    case (phase_reg)
                        PH_G1:   acc_one_next   = {acc_one_reg[27:0], dv};
                        PH_G2:   acc_two_next   = {acc_two_reg[11:0], dv};
                        PH_G3:   acc_three_next = {acc_three_reg[11:0], dv};
                        default: tail_wr        = 1'b1;
                    endcase
                    count_next = count_inc;
                end else if (s_ch == CH_DASH) begin
                    count_next = 4'd0;
                    phase_next = phase_t'(phase_reg + 4'd1);
                end else begin
                    err_next = ST_BAD_SEP;
                    if (s_ch == CH_NUL) begin
                        emit = 1'b1;
                    end else begin
                        phase_next = PH_DRAIN;
                    end
                end
            end
            PH_G5, PH_G6, PH_G7: begin
                if (hx) begin
                    slot    = 2'(PH_G7 - phase_reg);
                    tail_wr = 1'b1;
                    if (count_inc >= GRP_DIGITS) begin
                        count_next = 4'd0;
                        phase_next = phase_t'(phase_reg + 4'd1);
                    end else begin
                        count_next = count_inc;
                    end
                end else begin
                    // a non-hex char closes the remaining groups and starts the slash search
                    count_next = 4'd0;
                    phase_next = PH_SLASH;
                    post       = 1'b1;
                    post_phase = PH_SLASH;
                end
            end
            PH_SLASH, PH_SKIP1, PH_WHITE, PH_COMMENT: begin
                post = 1'b1;
            end
            default: begin
                if (s_ch == CH_NUL) begin
                    emit = 1'b1;
                end
            end
        endcase

        if (tail_wr) begin
            acc_tail_next[{slot, 4'd0} +: 16] = {acc_tail_reg[{slot, 4'd0} +: 12], dv};
        end

        if (post) begin
            if (s_ch == CH_NUL) begin
                emit = 1'b1;
            end else begin
                case (post_phase)
                    PH_SLASH: begin
                        if (s_ch == CH_SLASH) begin
                            slash_next = 1'b1;
                            phase_next = PH_SKIP1;
                        end
                    end
                    PH_SKIP1: begin
                        phase_next = PH_WHITE;
                    end
                    default: begin
                        if (!(post_phase == PH_WHITE &&
                              (s_ch == CH_SPACE || s_ch == CH_TAB))) begin
                            phase_next   = PH_COMMENT;
                            emit         = 1'b1;
                            m_kind_next  = KIND_COMMENT;
                            m_char_next  = s_ch;
                            m_found_next = 1'b1;
                        end
                    end
                endcase
            end
        end

        // final result at NUL, then back to the reset state
        if (emit && m_kind_next == KIND_RESULT) begin
            m_status_next = err_next;
            if (err_next == ST_OK) begin
                m_one_next   = acc_one_next;
                m_two_next   = acc_two_next;
                m_three_next = acc_three_next;
                m_tail_next  = acc_tail_next;
                m_found_next = slash_next;
            end
            phase_next     = PH_SEEK;
            count_next     = 4'd0;
            acc_one_next   = '0;
            acc_two_next   = '0;
            acc_three_next = '0;
            acc_tail_next  = '0;
            err_next       = ST_OK;
            slash_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SEEK;
            count_reg     <= 4'd0;
            acc_one_reg   <= '0;
            acc_two_reg   <= '0;
            acc_three_reg <= '0;
            acc_tail_reg  <= '0;
            err_reg       <= ST_OK;
            slash_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                acc_one_reg   <= acc_one_next;
                acc_two_reg   <= acc_two_next;
                acc_three_reg <= acc_three_next;
                acc_tail_reg  <= acc_tail_next;
                err_reg       <= err_next;
                slash_reg     <= slash_next;
            end
            if (accept && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output word payload, loaded only with a new word
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_kind_reg   <= m_kind_next;
            m_char_reg   <= m_char_next;
            m_status_reg <= m_status_next;
            m_one_reg    <= m_one_next;
            m_two_reg    <= m_two_next;
            m_three_reg  <= m_three_next;
            m_tail_reg   <= m_tail_next;
            m_found_reg  <= m_found_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_comment_char  = m_char_reg;
    assign m_status        = m_status_reg;
    assign m_part_one      = m_one_reg;
    assign m_part_two      = m_two_reg;
    assign m_part_three    = m_three_reg;
    assign m_tail_bytes    = m_tail_reg;
    assign m_comment_found = m_found_reg;

    a_comment_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_kind_reg == KIND_COMMENT |->
            m_status_reg == ST_OK && m_found_reg && m_one_reg == 32'd0 &&
            m_tail_reg == 64'd0)
        else $error("comment word carries parse fields");

    a_error_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != ST_OK |->
            m_kind_reg == KIND_RESULT && !m_found_reg && m_one_reg == 32'd0 &&
            m_two_reg == 16'd0 && m_three_reg == 16'd0 && m_tail_reg == 64'd0)
        else $error("error result carries nonzero fields");

    a_err_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg != ST_OK |-> phase_reg == PH_DRAIN)
        else $error("error code held outside drain phase");

    a_comment_slash: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SKIP1 || phase_reg == PH_WHITE || phase_reg == PH_COMMENT |->
            slash_reg)
        else $error("comment stage without slash");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_kind_reg) &&
            $stable(m_char_reg) && $stable(m_tail_reg))
        else $error("stalled output word changed");

endmodule

// File: bench/tb_guid_text_parser.sv
// ----------------------------------------------------------------------------
// tb_guid_text_parser
// Streams GUID strings, broken strings and noise into the parser one character
// word at a time, predicts every result word and comments word in the bench,
// and compares each m_* word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_guid_text_parser;
    import gtp_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;

    typedef enum logic [3:0] {
        P_SEEK, P_GRP1, P_GRP2, P_GRP3, P_GRP4, P_GRP5, P_GRP6, P_GRP7,
        P_FIND_SLASH, P_SKIP_ONE, P_SKIP_WS, P_TEXT, P_DRAIN
    } parse_phase_e;

    typedef struct {
        logic        kind;
        char_t       comment_char;
        status_t     status;
        logic [31:0] part_one;
        logic [15:0] part_two;
        logic [15:0] part_three;
        logic [63:0] tail_bytes;
        logic        comment_found;
    } out_word_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    char_t       s_ch;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    char_t       m_comment_char;
    status_t     m_status;
    logic [31:0] m_part_one;
    logic [15:0] m_part_two;
    logic [15:0] m_part_three;
    logic [63:0] m_tail_bytes;
    logic        m_comment_found;

    guid_text_parser uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ch            (s_ch),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_comment_char  (m_comment_char),
        .m_status        (m_status),
        .m_part_one      (m_part_one),
        .m_part_two      (m_part_two),
        .m_part_three    (m_part_three),
        .m_tail_bytes    (m_tail_bytes),
        .m_comment_found (m_comment_found)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // parser model state
    parse_phase_e cur_phase;
    int           ndigits;
    logic [31:0]  grp_one;
    logic [15:0]  grp_two;
    logic [15:0]  grp_three;
    logic [63:0]  tail_acc;
    status_t      err_st;
    logic         have_slash;

    out_word_t pending_words[$];
    int        mismatches = 0;
    int        chars_sent = 0;
    bit        idle_en = 1'b1;
    int        stall_left = 0;
    int        quiet_cycles = 0;

    function automatic bit hex_digit(input char_t c, output logic [3:0] v);
        v = 4'd0;
        hex_digit = 1'b1;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            v = c[3:0];
        end else if (c >= 16'h0061 && c <= 16'h0066) begin
            v = 4'(c - 16'h0057);
        end else if (c >= 16'h0041 && c <= 16'h0046) begin
            v = 4'(c - 16'h0037);
        end else begin
            hex_digit = 1'b0;
        end
    endfunction

    function automatic void clear_parser();
        cur_phase  = P_SEEK;
        ndigits    = 0;
        grp_one    = '0;
        grp_two    = '0;
        grp_three  = '0;
        tail_acc   = '0;
        err_st     = ST_OK;
        have_slash = 1'b0;
    endfunction

    function automatic void emit_result();
        out_word_t w;
        w = '{kind: KIND_RESULT, comment_char: '0, status: err_st, part_one: '0,
              part_two: '0, part_three: '0, tail_bytes: '0, comment_found: 1'b0};
        if (err_st == ST_OK) begin
            w.part_one      = grp_one;
            w.part_two      = grp_two;
            w.part_three    = grp_three;
            w.tail_bytes    = tail_acc;
            w.comment_found = have_slash;
        end
        pending_words.push_back(w);
        clear_parser();
    endfunction

    function automatic void separator_fault(input char_t c);
        err_st = ST_BAD_SEP;
        if (c == CH_NUL) emit_result();
        else cur_phase = P_DRAIN;
    endfunction

    // advance the parser model by one accepted character
    function automatic void parse_char(input char_t c);
        out_word_t  w;
        logic [3:0] d;
        bit         hx;
        bit         after_guid;
        int         sh;
        hx = hex_digit(c, d);
        after_guid = 1'b0;
        case (cur_phase)
            P_SEEK: begin
                if (hx) begin
                    grp_one   = {28'd0, d};
                    ndigits   = 1;
                    cur_phase = P_GRP1;
                end else if (c == CH_NUL) begin
                    err_st = ST_NO_HEX;
                    emit_result();
                end
            end
            P_GRP1: begin
                if (hx && ndigits < G1_DIGITS) begin
                    grp_one = {grp_one[27:0], d};
                    ndigits++;
                end else if (c != CH_DASH) begin
                    separator_fault(c);
                end else begin
                    ndigits   = 0;
                    cur_phase = P_GRP2;
                end
            end
            P_GRP2, P_GRP3, P_GRP4: begin
                if (hx && ndigits < GRP_DIGITS) begin
                    if (cur_phase == P_GRP2) grp_two = {grp_two[11:0], d};
                    else if (cur_phase == P_GRP3) grp_three = {grp_three[11:0], d};
                    else tail_acc[63:48] = {tail_acc[59:48], d};
                    ndigits++;
                end else if (c != CH_DASH) begin
                    separator_fault(c);
                end else begin
                    ndigits   = 0;
                    cur_phase = parse_phase_e'(cur_phase + 1);
                end
            end
            P_GRP5, P_GRP6, P_GRP7: begin
                if (hx) begin
                    sh = 16 * (P_GRP7 - cur_phase);
                    tail_acc[sh +: 16] = {tail_acc[sh +: 12], d};
                    ndigits++;
                    if (ndigits >= GRP_DIGITS) begin
                        ndigits   = 0;
                        cur_phase = parse_phase_e'(cur_phase + 1);
                    end
                end else begin
                    // a non-hex char closes all remaining groups and is looked at again
                    ndigits    = 0;
                    cur_phase  = P_FIND_SLASH;
                    after_guid = 1'b1;
                end
            end
            P_FIND_SLASH, P_SKIP_ONE, P_SKIP_WS, P_TEXT: after_guid = 1'b1;
            default: if (c == CH_NUL) emit_result();
        endcase
        if (after_guid) begin
            if (c == CH_NUL) begin
                emit_result();
            end else if (cur_phase == P_FIND_SLASH) begin
                if (c == CH_SLASH) begin
                    have_slash = 1'b1;
                    cur_phase  = P_SKIP_ONE;
                end
            end else if (cur_phase == P_SKIP_ONE) begin
                cur_phase = P_SKIP_WS;
            end else if (!(cur_phase == P_SKIP_WS && (c == CH_SPACE || c == CH_TAB))) begin
                cur_phase = P_TEXT;
                w = '{kind: KIND_COMMENT, comment_char: c, status: ST_OK, part_one: '0,
                      part_two: '0, part_three: '0, tail_bytes: '0, comment_found: 1'b1};
                pending_words.push_back(w);
            end
        end
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic char_t rand_char();
        if ($urandom_range(0, 1)) rand_char = char_t'($urandom_range(1, 65535));
        else rand_char = char_t'($urandom_range(32, 126));
    endfunction

    function automatic char_t rand_nonhex();
        char_t      c;
        logic [3:0] v;
        do c = rand_char(); while (hex_digit(c, v) || c == CH_DASH);
        rand_nonhex = c;
    endfunction

    function automatic char_t hex_char(input logic [3:0] v);
        if (v < 4'd10) hex_char = 16'h0030 + v;
        else if ($urandom_range(0, 1)) hex_char = 16'h0061 + v - 16'd10;
        else hex_char = 16'h0041 + v - 16'd10;
    endfunction

    function automatic char_t noise_char();
        int r;
        r = $urandom_range(0, 19);
        if (r < 6) noise_char = hex_char(4'($urandom_range(0, 15)));
        else if (r < 8) noise_char = CH_DASH;
        else if (r < 9) noise_char = CH_SLASH;
        else if (r < 10) noise_char = $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
        else if (r < 11) noise_char = CH_NUL;
        else noise_char = rand_char();
    endfunction

    task automatic send_char(input char_t c);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_ch    <= c;
        do @(posedge aclk); while (!s_ready);
        parse_char(c);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) send_char({8'h00, s[i]});
    endtask

    // one GUID string; with corrupt set, one separator is replaced by a wrong char
    task automatic send_guid(input bit corrupt);
        int g;
        int n;
        int full;
        int bad_at;
        int r;
        bad_at = $urandom_range(0, 3);
        if ($urandom_range(0, 1)) send_str("{");
        repeat ($urandom_range(0, 2)) send_char(rand_nonhex());
        for (g = 0; g < 4; g++) begin
            full = (g == 0) ? G1_DIGITS : GRP_DIGITS;
            n = ($urandom_range(0, 3) != 0) ? full : $urandom_range(g == 0 ? 1 : 0, full);
            repeat (n) send_char(hex_char(4'($urandom_range(0, 15))));
            if (corrupt && g == bad_at) begin
                r = $urandom_range(0, 2);
                if (r == 0) send_char(CH_NUL);
                else if (r == 1 && n == full) send_char(hex_char(4'($urandom_range(0, 15))));
                else send_char(rand_nonhex());
                repeat ($urandom_range(0, 6)) send_char(noise_char());
                send_char(CH_NUL);
                return;
            end
            send_char(CH_DASH);
        end
        n = ($urandom_range(0, 3) != 0) ? 12 : $urandom_range(0, 11);
        repeat (n) send_char(hex_char(4'($urandom_range(0, 15))));
        if ($urandom_range(0, 9) == 0) begin
            send_char(CH_NUL);
            return;
        end
        if ($urandom_range(0, 1)) send_str("}");
        if ($urandom_range(0, 3) != 0) begin
            send_char(CH_SLASH);
            if ($urandom_range(0, 7) == 0) begin
                send_char(CH_NUL);
                return;
            end
            send_char(rand_char());
            repeat ($urandom_range(0, 3)) send_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            repeat ($urandom_range(0, 8)) send_char(rand_char());
        end
        send_char(CH_NUL);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 20)) send_char(noise_char());
        send_char(CH_NUL);
    endtask

    // ---------------- tests ----------------

    task automatic test_no_hex();
        send_char(CH_NUL);
        send_str("G");
        send_char(CH_NUL);
    endtask

    task automatic test_bad_separator();
        // non-hex where a dash belongs, then NUL itself as the faulty separator
        send_str("Fg");
        send_char(CH_NUL);
        send_str("a");
        send_char(CH_NUL);
    endtask

    task automatic test_short_groups_comment();
        send_str("9-A-f-0-:/\t ");
        send_char(16'hFFFF);
        send_char(CH_NUL);
    endtask

    task automatic test_empty_comment();
        send_str("1----/");
        send_char(CH_NUL);
    endtask

    task automatic test_random_guids();
        while (chars_sent < 1200) send_guid(1'b0);
    endtask

    task automatic test_broken_and_noise();
        int r;
        while (chars_sent < 1650) begin
            r = $urandom_range(0, 2);
            if (r == 0) send_guid(1'b1);
            else if (r == 1) send_noise();
            else send_guid(1'b0);
        end
    endtask

    task automatic test_steady_stream();
        idle_en = 1'b0;
        while (chars_sent < 1950) begin
            if ($urandom_range(0, 3) != 0) send_guid($urandom_range(0, 5) == 0);
            else send_noise();
        end
    endtask

    // ---------------- result side ----------------

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected result word: kind %0b status %0d", m_kind, m_status);
                mismatches++;
            end else begin
                want = pending_words.pop_front();
                check_field("kind", want.kind, m_kind);
                check_field("comment_char", want.comment_char, m_comment_char);
                check_field("status", want.status, m_status);
                check_field("part_one", want.part_one, m_part_one);
                check_field("part_two", want.part_two, m_part_two);
                check_field("part_three", want.part_three, m_part_three);
                check_field("tail_bytes", want.tail_bytes, m_tail_bytes);
                check_field("comment_found", want.comment_found, m_comment_found);
            end
        end
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_ch    = CH_NUL;
        clear_parser();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_no_hex();
        test_bad_separator();
        test_short_groups_comment();
        test_empty_comment();
        test_random_guids();
        test_broken_and_noise();
        test_steady_stream();

        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/gtp_pkg.sv
rtl/core/guid_text_parser.sv
bench/tb_guid_text_parser.sv
